@@ rtl/core/pim_pkg.sv @@
// Shared types and codes for the priority inheritance mutex.
package pim_pkg;

    // Request kinds, carried on the input tuser bit
    localparam logic CMD_LOCK   = 1'b0;
    localparam logic CMD_UNLOCK = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_BLOCKED  = 3'd1,
        ST_RELEASED = 3'd2,
        ST_HANDOFF  = 3'd3,
        ST_FAULT    = 3'd4,
        ST_FULL     = 3'd5
    } t_status;

    // Fixed field widths
    localparam int TID_W  = 4;
    localparam int PRIO_W = 7;

    // Result transaction, first field in the highest bits
    typedef struct packed {
        logic              switch_request;
        logic [TID_W-1:0]  woken_task;
        logic              priority_changed;
        logic [PRIO_W-1:0] new_priority;
        logic [TID_W-1:0]  priority_task;
        logic              owner_valid;
        logic [TID_W-1:0]  owner_task;
        t_status           status;
    } t_result;

    localparam int RES_W = $bits(t_result);
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;
    localparam int IN_W  = ((TID_W + PRIO_W + 7) / 8) * 8;

    // Waiter list entry
    typedef struct packed {
        logic [TID_W-1:0]  id;
        logic [PRIO_W-1:0] prio;
    } t_waiter;

endpackage

@@ rtl/core/priority_inheritance_mutex.sv @@
// Priority inheritance mutex: request decode, waiter list and handoff sequencer.
//
//  Channel  Direction  Transaction contents
//  s        in         tuser: cmd; tdata: task_id, task_priority
//  m        out        tdata: status, owner_task, owner_valid, priority_task,
//                             new_priority, priority_changed, woken_task,
//                             switch_request
//
// A lock, a release or a fault passes from acceptance through the decide and emit states to the result register.
// An unlock that hands off first reads the N waiters one per
// cycle through the single read port of the waiter memory to find the most
// urgent one, then S = N - 1 - winner index entries are moved down one a cycle.
// Reset clears the mutex state and the waiter count; no clearing pass.
// The input is taken only while the sequencer is idle; a finished result holds
// in the sequencer until the output register is free.
module priority_inheritance_mutex
    import pim_pkg::*;
#(
    parameter int MAX_WAITERS = 8,
    parameter int MAX_TASKS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // [3:0] task_id, [10:4] task_priority
    input  logic [0:0]       i_s_tuser,   // [0] cmd
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // [2:0] status, [6:3] owner_task,
                                          // [7] owner_valid, [11:8] priority_task,
                                          // [18:12] new_priority, [19] priority_changed,
                                          // [23:20] woken_task, [24] switch_request
);

    localparam int AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WAITERS);
    localparam logic [8:0]    TASK_LIMIT = 9'(MAX_TASKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_SHIFT,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic                r_cmd;
    logic [TID_W-1:0]    r_tid;
    logic [PRIO_W-1:0]   r_prio;
    t_result             r_res;
    logic                r_held;
    logic [TID_W-1:0]    r_owner;
    logic [PRIO_W-1:0]   r_base;
    logic [PRIO_W-1:0]   r_eff;
    logic [CW-1:0]       r_count;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       r_best_idx;
    logic [TID_W-1:0]    r_best_id;
    logic [PRIO_W-1:0]   r_best_prio;
    logic                r_m_valid;
    t_result             r_m_data;

    // Waiter memory: one write and one registered read port
    t_waiter             r_wait_mem [MAX_WAITERS];
    t_waiter             r_rd;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    t_waiter             mem_wd;
    logic [AW-1:0]       mem_ra;

    logic                take;
    logic [AW-1:0]       n_best_idx;
    logic [TID_W-1:0]    n_best_id;
    logic [PRIO_W-1:0]   n_best_prio;
    logic                fin;
    logic                s_accept;
    logic                emit_ok;
    logic [CW:0]         idx_p1;
    logic [CW:0]         idx_p2;
    logic [CW:0]         best_p1;

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign emit_ok    = !r_m_valid || i_m_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'(r_m_data);

    assign idx_p1 = (CW + 1)'(r_idx) + (CW + 1)'(1);
    assign idx_p2 = (CW + 1)'(r_idx) + (CW + 1)'(2);

    // Compare unit for the scan: strictly greater wins, so the earliest tie stays
    assign take        = (r_idx == '0) || (r_rd.prio > r_best_prio);
    assign n_best_idx  = take ? r_idx   : r_best_idx;
    assign n_best_id   = take ? r_rd.id : r_best_id;
    assign n_best_prio = take ? r_rd.prio : r_best_prio;
    assign best_p1     = (CW + 1)'(n_best_idx) + (CW + 1)'(1);

    // Memory port control and end of handoff
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_count[AW-1:0];
        mem_wd = '{id: r_tid, prio: r_prio};
        mem_ra = '0;
        fin    = 1'b0;
        case (r_state)
            S_DECIDE: begin
                // append on a lock that blocks
                if (r_cmd == CMD_LOCK && r_held && r_count < CNT_MAX
                    && {5'd0, r_tid} < TASK_LIMIT) begin
                    mem_we = 1'b1;
                end
            end
            S_SCAN: begin
                if (idx_p1 < (CW + 1)'(r_count)) begin
                    mem_ra = idx_p1[AW-1:0];
                end else if (best_p1 < (CW + 1)'(r_count)) begin
                    mem_ra = best_p1[AW-1:0];
                end else begin
                    fin = 1'b1;
                end
            end
            S_SHIFT: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_rd;
                if (idx_p2 < (CW + 1)'(r_count)) begin
                    mem_ra = idx_p2[AW-1:0];
                end else begin
                    fin = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Waiter memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_wait_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_wait_mem[mem_ra];
    end

    // Sequencer, mutex state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_held    <= 1'b0;
            r_owner   <= '0;
            r_base    <= '0;
            r_eff     <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_cmd   <= i_s_tuser[0];
                        r_tid   <= i_s_tdata[TID_W-1:0];
                        r_prio  <= i_s_tdata[TID_W+PRIO_W-1:TID_W];
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res   <= '0;
                    r_state <= S_EMIT;
                    if ({5'd0, r_tid} >= TASK_LIMIT) begin
                        r_res.status <= ST_FAULT;
                    end else if (r_cmd == CMD_LOCK) begin
                        if (!r_held) begin
                            r_held       <= 1'b1;
                            r_owner      <= r_tid;
                            r_base       <= r_prio;
                            r_eff        <= r_prio;
                            r_res.status <= ST_GRANTED;
                        end else if (r_count >= CNT_MAX) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            // queue the task and raise the owner if needed
                            r_count              <= r_count + CW'(1);
                            r_res.status         <= ST_BLOCKED;
                            r_res.switch_request <= 1'b1;
                            if (r_prio > r_eff) begin
                                r_eff                  <= r_prio;
                                r_res.priority_task    <= r_owner;
                                r_res.new_priority     <= r_prio;
                                r_res.priority_changed <= 1'b1;
                            end
                        end
                    end else if (!r_held || r_tid != r_owner) begin
                        r_res.status <= ST_FAULT;
                    end else begin
                        // owner unlock: restore base priority
                        if (r_eff != r_base) begin
                            r_res.priority_task    <= r_owner;
                            r_res.new_priority     <= r_base;
                            r_res.priority_changed <= 1'b1;
                        end
                        if (r_count == '0) begin
                            r_held       <= 1'b0;
                            r_owner      <= '0;
                            r_base       <= '0;
                            r_eff        <= '0;
                            r_res.status <= ST_RELEASED;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_best_idx  <= n_best_idx;
                    r_best_id   <= n_best_id;
                    r_best_prio <= n_best_prio;
                    if (idx_p1 < (CW + 1)'(r_count)) begin
                        r_idx <= idx_p1[AW-1:0];
                    end else if (!fin) begin
                        r_idx   <= n_best_idx;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!fin) begin
                        r_idx <= idx_p1[AW-1:0];
                    end
                end
                S_EMIT: begin
                    if (emit_ok) begin
                        r_m_data             <= r_res;
                        r_m_data.owner_valid <= r_held;
                        r_m_data.owner_task  <= r_held ? r_owner : '0;
                        r_m_valid            <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // handoff to the winning waiter
            if (fin) begin
                r_count              <= r_count - CW'(1);
                r_owner              <= (r_state == S_SCAN) ? n_best_id : r_best_id;
                r_base               <= (r_state == S_SCAN) ? n_best_prio : r_best_prio;
                r_eff                <= (r_state == S_SCAN) ? n_best_prio : r_best_prio;
                r_res.status         <= ST_HANDOFF;
                r_res.woken_task     <= (r_state == S_SCAN) ? n_best_id : r_best_id;
                r_res.switch_request <= 1'b1;
                r_state              <= S_EMIT;
            end
        end
    end

    // Waiter count stays within the list
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("waiter count beyond list size");

    // A free mutex has no waiters
    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_count == '0))
        else $error("waiters on a free mutex");

    // Inheritance only raises the owner's priority
    a_eff_ge_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eff >= r_base)
        else $error("effective priority below base");

    // An accepted transaction goes straight to decode
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state == S_DECIDE))
        else $error("accepted transaction not decoded");

endmodule
